### hw/rtl/pn3_pkg.sv
// pn3_pkg: shared constants and command codes for the 3D Perlin noise block.
// No dependencies.
`default_nettype none
package pn3_pkg;
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    localparam int HASH_W      = 4;    // gradient select bits taken from a hash
    localparam int NUM_CORNERS = 8;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = 3;
    localparam int CREDIT_W    = 4;
    localparam int PERM_W      = 8;
    localparam int NOISE_W     = 17;
    localparam logic [NOISE_W-1:0] NOISE_MAX = 17'd65536;

    // queue handshake between front and back
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;
endpackage
`default_nettype wire

### hw/rtl/perlin_noise_3d.sv
// perlin_noise_3d: top level of the 3D improved Perlin noise block.
// Depends on pn3_pkg, pn3_front, pn3_fifo, pn3_back, pn3_ram.
//
// Usage:
//   A request is taken on a clock edge with start high and busy low.
//   i_op selects a table load (i_table_index, i_table_value) or a noise
//   evaluation at (i_coord_x, i_coord_y, i_coord_z), signed fixed point.
//   Load all table entries before the first evaluation.
//   Each evaluation returns one o_noise_value, shown for one cycle with
//   o_valid high; loads return nothing. Results come out in request order.
//   Throughput: one request per cycle while busy is low. The pipeline has
//   ten register stages (4 front stages set by the input register and the
//   three registered table lookup levels, the queue, 5 blend stages set by
//   the gradient dot products, the three chained interpolation multiplies
//   and the output scaling). busy rises only if the queue credit runs out,
//   which the back end, draining every cycle, prevents.
//   Reset (synchronous, active low) empties the pipeline and the queue;
//   table contents are kept and are undefined until loaded.
//   The receiver cannot stall; every result must be taken when shown.
`default_nettype none
module perlin_noise_3d #(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_op,
    input  wire logic [7:0]                    i_table_index,
    input  wire logic [7:0]                    i_table_value,
    input  wire logic [31:0]                   i_coord_x,
    input  wire logic [31:0]                   i_coord_y,
    input  wire logic [31:0]                   i_coord_z,
    output logic                               o_valid,
    output logic [pn3_pkg::NOISE_W-1:0]        o_noise_value
);
    localparam int F  = FRAC_BITS;
    localparam int EW = pn3_pkg::NUM_CORNERS * pn3_pkg::HASH_W + 3 * F + 3 * (F + 1);

    logic                         accept, eval_acc, q_empty;
    logic [EW-1:0]                f_entry, q_entry;
    pn3_pkg::t_q_ctl              q_ctl;
    logic [pn3_pkg::CREDIT_W-1:0] r_inflight;

    assign accept   = start && !busy;
    assign eval_acc = accept && (i_op == pn3_pkg::OP_EVAL);
    assign q_ctl.pop = !q_empty;

    // evaluations between accept and queue pop; bounds queue occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + pn3_pkg::CREDIT_W'(eval_acc)
                                     - pn3_pkg::CREDIT_W'(q_ctl.pop);
        end
    end

    assign busy = (r_inflight >= pn3_pkg::CREDIT_W'(pn3_pkg::FIFO_DEPTH));

    pn3_front #(.TABLE_SIZE(TABLE_SIZE), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_accept(accept), .i_op, .i_table_index, .i_table_value,
        .i_coord_x, .i_coord_y, .i_coord_z,
        .o_push(q_ctl.push), .o_entry(f_entry)
    );

    pn3_fifo #(.WIDTH(EW)) u_fifo (
        .i_clk, .i_rst_n, .i_ctl(q_ctl), .i_data(f_entry),
        .o_data(q_entry), .o_empty(q_empty)
    );

    pn3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_ctl.pop), .i_entry(q_entry),
        .o_valid, .o_noise_value
    );
endmodule
`default_nettype wire

### hw/rtl/pn3_ram.sv
// pn3_ram: generic RAM, one write port, two registered read ports.
// No dependencies.
`default_nettype none
module pn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

### hw/rtl/pn3_front.sv
// pn3_front: splits coordinates, runs the fade polynomial and the three
// levels of permutation lookups. Depends on pn3_pkg and pn3_ram.
`default_nettype none
module pn3_front #(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS  = 16,
    localparam int TW = $clog2(TABLE_SIZE),
    localparam int F  = FRAC_BITS,
    localparam int EW = pn3_pkg::NUM_CORNERS * pn3_pkg::HASH_W + 3 * F + 3 * (F + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_op,
    input  wire logic [7:0]    i_table_index,
    input  wire logic [7:0]    i_table_value,
    input  wire logic [31:0]   i_coord_x,
    input  wire logic [31:0]   i_coord_y,
    input  wire logic [31:0]   i_coord_z,
    output logic               o_push,
    output logic [EW-1:0]      o_entry
);
    localparam int KW = F + 6;
    localparam int PW = 2 * F + 8;
    localparam logic [KW-1:0] K15 = KW'(15) << F;
    localparam logic [KW-1:0] K10 = KW'(10) << F;
    localparam logic [F:0]    ONE = (F + 1)'(1) << F;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (F - 1);

    // stage control and load request payload
    logic          r_vld [1:4];
    logic          r_op  [1:4];
    logic [TW-1:0] r_widx [1:3];
    logic [7:0]    r_wval [1:3];

    logic [TW-1:0] r1_cell [3];
    logic [TW-1:0] r2_iy, r2_iz, r3_iz;
    logic [F-1:0]  r_frac [1:4][3];

    // fade pipeline per lane
    logic signed [KW-1:0] r2_cpre [3];
    logic        [F:0]    r2_t2   [3];
    logic signed [KW-1:0] r3_c    [3];
    logic        [F:0]    r3_t3   [3];
    logic        [F:0]    r4_fade [3];

    logic signed [KW-1:0] n_cpre [3];
    logic        [F:0]    n_t2   [3];
    logic        [F:0]    n_t3   [3];
    logic        [F:0]    n_fade [3];

    always_comb begin
        logic        [KW-1:0] k;
        logic signed [PW-1:0] p;
        for (int l = 0; l < 3; l++) begin
            k = ({6'b0, r_frac[1][l]} << 2) + ({6'b0, r_frac[1][l]} << 1) - K15;
            p = $signed({1'b0, r_frac[1][l]}) * $signed(k);
            n_cpre[l] = KW'((p + HALF) >>> F);
            p = $signed({1'b0, r_frac[1][l]}) * $signed({1'b0, r_frac[1][l]});
            n_t2[l] = (F + 1)'((p + HALF) >>> F);
            p = $signed({1'b0, r2_t2[l]}) * $signed({1'b0, r_frac[2][l]});
            n_t3[l] = (F + 1)'((p + HALF) >>> F);
            p = $signed({1'b0, r3_t3[l]}) * r3_c[l];
            p = (p + HALF) >>> F;
            if (p < 0) begin
                n_fade[l] = '0;
            end else if (p > $signed(PW'(ONE))) begin
                n_fade[l] = ONE;
            end else begin
                n_fade[l] = (F + 1)'(p);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 4; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[1] <= i_accept;
            for (int s = 2; s <= 4; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] fl;
        r_op[1]   <= i_op;
        r_widx[1] <= TW'(i_table_index);
        r_wval[1] <= i_table_value;
        fl = $signed(i_coord_x) >>> F;
        r1_cell[0] <= TW'(fl);
        fl = $signed(i_coord_y) >>> F;
        r1_cell[1] <= TW'(fl);
        fl = $signed(i_coord_z) >>> F;
        r1_cell[2] <= TW'(fl);
        r_frac[1][0] <= F'(i_coord_x);
        r_frac[1][1] <= F'(i_coord_y);
        r_frac[1][2] <= F'(i_coord_z);
        for (int s = 2; s <= 4; s++) begin
            r_op[s] <= r_op[s-1];
            r_frac[s] <= r_frac[s-1];
        end
        for (int s = 2; s <= 3; s++) begin
            r_widx[s] <= r_widx[s-1];
            r_wval[s] <= r_wval[s-1];
        end
        r2_iy <= r1_cell[1];
        r2_iz <= r1_cell[2];
        r3_iz <= r2_iz;
        for (int l = 0; l < 3; l++) begin
            r2_cpre[l] <= n_cpre[l];
            r2_t2[l]   <= n_t2[l];
            r3_c[l]    <= r2_cpre[l] + $signed(K10);
            r3_t3[l]   <= n_t3[l];
            r4_fade[l] <= n_fade[l];
        end
    end

    // lookup levels; each level's copies are written in its own stage so
    // loads and evaluates keep their order at every level
    logic [7:0] p_ix, p_ix1, p_a, p_a1, p_b, p_b1;
    logic [7:0] h_rd [pn3_pkg::NUM_CORNERS];
    logic [TW-1:0] a_addr, b_addr, aa, ab, ba, bb;
    logic we1, we2, we3;

    assign we1 = r_vld[1] && (r_op[1] == pn3_pkg::OP_LOAD);
    assign we2 = r_vld[2] && (r_op[2] == pn3_pkg::OP_LOAD);
    assign we3 = r_vld[3] && (r_op[3] == pn3_pkg::OP_LOAD);

    pn3_ram #(.WIDTH(pn3_pkg::PERM_W), .DEPTH(TABLE_SIZE)) u_ram_l1 (
        .i_clk, .i_we(we1), .i_waddr(r_widx[1]), .i_wdata(r_wval[1]),
        .i_raddr_a(r1_cell[0]), .i_raddr_b(r1_cell[0] + TW'(1)),
        .o_rdata_a(p_ix), .o_rdata_b(p_ix1)
    );

    assign a_addr = TW'(p_ix) + r2_iy;
    assign b_addr = TW'(p_ix1) + r2_iy;

    pn3_ram #(.WIDTH(pn3_pkg::PERM_W), .DEPTH(TABLE_SIZE)) u_ram_l2a (
        .i_clk, .i_we(we2), .i_waddr(r_widx[2]), .i_wdata(r_wval[2]),
        .i_raddr_a(a_addr), .i_raddr_b(a_addr + TW'(1)),
        .o_rdata_a(p_a), .o_rdata_b(p_a1)
    );
    pn3_ram #(.WIDTH(pn3_pkg::PERM_W), .DEPTH(TABLE_SIZE)) u_ram_l2b (
        .i_clk, .i_we(we2), .i_waddr(r_widx[2]), .i_wdata(r_wval[2]),
        .i_raddr_a(b_addr), .i_raddr_b(b_addr + TW'(1)),
        .o_rdata_a(p_b), .o_rdata_b(p_b1)
    );

    assign aa = TW'(p_a)  + r3_iz;
    assign ab = TW'(p_a1) + r3_iz;
    assign ba = TW'(p_b)  + r3_iz;
    assign bb = TW'(p_b1) + r3_iz;

    // corner order: bit0 = x+1, bit1 = y+1, bit2 = z+1
    pn3_ram #(.WIDTH(pn3_pkg::PERM_W), .DEPTH(TABLE_SIZE)) u_ram_aa (
        .i_clk, .i_we(we3), .i_waddr(r_widx[3]), .i_wdata(r_wval[3]),
        .i_raddr_a(aa), .i_raddr_b(aa + TW'(1)),
        .o_rdata_a(h_rd[0]), .o_rdata_b(h_rd[4])
    );
    pn3_ram #(.WIDTH(pn3_pkg::PERM_W), .DEPTH(TABLE_SIZE)) u_ram_ba (
        .i_clk, .i_we(we3), .i_waddr(r_widx[3]), .i_wdata(r_wval[3]),
        .i_raddr_a(ba), .i_raddr_b(ba + TW'(1)),
        .o_rdata_a(h_rd[1]), .o_rdata_b(h_rd[5])
    );
    pn3_ram #(.WIDTH(pn3_pkg::PERM_W), .DEPTH(TABLE_SIZE)) u_ram_ab (
        .i_clk, .i_we(we3), .i_waddr(r_widx[3]), .i_wdata(r_wval[3]),
        .i_raddr_a(ab), .i_raddr_b(ab + TW'(1)),
        .o_rdata_a(h_rd[2]), .o_rdata_b(h_rd[6])
    );
    pn3_ram #(.WIDTH(pn3_pkg::PERM_W), .DEPTH(TABLE_SIZE)) u_ram_bb (
        .i_clk, .i_we(we3), .i_waddr(r_widx[3]), .i_wdata(r_wval[3]),
        .i_raddr_a(bb), .i_raddr_b(bb + TW'(1)),
        .o_rdata_a(h_rd[3]), .o_rdata_b(h_rd[7])
    );

    assign o_push = r_vld[4] && (r_op[4] == pn3_pkg::OP_EVAL);

    always_comb begin
        for (int c = 0; c < pn3_pkg::NUM_CORNERS; c++) begin
            o_entry[c*pn3_pkg::HASH_W +: pn3_pkg::HASH_W] = h_rd[c][pn3_pkg::HASH_W-1:0];
        end
        for (int l = 0; l < 3; l++) begin
            o_entry[pn3_pkg::NUM_CORNERS*pn3_pkg::HASH_W + l*F +: F] = r_frac[4][l];
            o_entry[pn3_pkg::NUM_CORNERS*pn3_pkg::HASH_W + 3*F + l*(F+1) +: F+1] = r4_fade[l];
        end
    end
endmodule
`default_nettype wire

### hw/rtl/pn3_fifo.sv
// pn3_fifo: short request queue between the lookup front and the blend back.
// Depends on pn3_pkg.
`default_nettype none
module pn3_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire pn3_pkg::t_q_ctl       i_ctl,
    input  wire logic [WIDTH-1:0]      i_data,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty
);
    logic [WIDTH-1:0]            r_mem [pn3_pkg::FIFO_DEPTH];
    logic [pn3_pkg::FIFO_AW-1:0] r_wr, r_rd;
    logic [pn3_pkg::FIFO_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_ctl.pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (pn3_pkg::FIFO_AW + 1)'(i_ctl.push)
                           - (pn3_pkg::FIFO_AW + 1)'(i_ctl.pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
endmodule
`default_nettype wire

### hw/rtl/pn3_back.sv
// pn3_back: gradient dot products, trilinear blend and output scaling.
// Depends on pn3_pkg.
`default_nettype none
module pn3_back #(
    parameter int FRAC_BITS = 16,
    localparam int F  = FRAC_BITS,
    localparam int EW = pn3_pkg::NUM_CORNERS * pn3_pkg::HASH_W + 3 * F + 3 * (F + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [EW-1:0]                i_entry,
    output logic                              o_valid,
    output logic [pn3_pkg::NOISE_W-1:0]       o_noise_value
);
    localparam int XW = F + 2;
    localparam int GW = F + 3;
    localparam int LW = F + 4;
    localparam int PW = 2 * F + 8;
    localparam int VW = LW + 9;
    localparam int SH_R = (F > 15) ? F - 15 : 0;
    localparam int SH_L = (F > 15) ? 0 : 15 - F;
    localparam logic [VW-1:0] RND = (F > 15) ? (VW'(1) << (SH_R - 1)) : '0;
    localparam logic signed [XW-1:0] ONE_X = XW'(1) << F;
    localparam logic signed [LW:0]   ONE_L = (LW + 1)'(1) << F;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (F - 1);
    localparam int HB = pn3_pkg::NUM_CORNERS * pn3_pkg::HASH_W;

    function automatic logic signed [GW-1:0] grad(
        input logic [pn3_pkg::HASH_W-1:0] h,
        input logic signed [XW-1:0] x,
        input logic signed [XW-1:0] y,
        input logic signed [XW-1:0] z
    );
        logic signed [GW-1:0] u, v;
        u = (h < 4'd8) ? GW'(x) : GW'(y);
        v = (h < 4'd4) ? GW'(y) : ((h == 4'd12 || h == 4'd14) ? GW'(x) : GW'(z));
        if (h[0]) u = -u;
        if (h[1]) v = -v;
        return u + v;
    endfunction

    function automatic logic signed [LW-1:0] lerp(
        input logic [F:0] t,
        input logic signed [LW-1:0] a,
        input logic signed [LW-1:0] b
    );
        logic signed [LW:0]   d;
        logic signed [PW-1:0] p;
        d = (LW + 1)'(b) - (LW + 1)'(a);
        p = $signed({1'b0, t}) * d;
        p = (p + HALF) >>> F;
        return LW'((LW + 1)'(a) + (LW + 1)'(p));
    endfunction

    logic                  r_vld [1:5];
    logic signed [GW-1:0]  r1_g [pn3_pkg::NUM_CORNERS];
    logic [F:0]            r1_u, r1_v, r1_w, r2_v, r2_w, r3_w;
    logic signed [LW-1:0]  r2_lx [4];
    logic signed [LW-1:0]  r3_ly [2];
    logic signed [LW-1:0]  r4_res;

    logic signed [XW-1:0]  n_x [2], n_y [2], n_z [2];
    logic signed [LW:0]    n_val;
    logic [VW-1:0]         n_scaled;

    always_comb begin
        n_x[0] = XW'(i_entry[HB +: F]);
        n_y[0] = XW'(i_entry[HB + F +: F]);
        n_z[0] = XW'(i_entry[HB + 2*F +: F]);
        n_x[1] = n_x[0] - ONE_X;
        n_y[1] = n_y[0] - ONE_X;
        n_z[1] = n_z[0] - ONE_X;
    end

    always_comb begin
        n_val = (LW + 1)'(r4_res) + ONE_L;
        if (n_val < 0) begin
            n_val = '0;
        end
        n_scaled = ((VW'(n_val) + RND) >> SH_R) << SH_L;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 5; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[1] <= i_valid;
            for (int s = 2; s <= 5; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < pn3_pkg::NUM_CORNERS; c++) begin
            r1_g[c] <= grad(i_entry[c*pn3_pkg::HASH_W +: pn3_pkg::HASH_W],
                            n_x[c & 1], n_y[(c >> 1) & 1], n_z[(c >> 2) & 1]);
        end
        r1_u <= i_entry[HB + 3*F +: F+1];
        r1_v <= i_entry[HB + 3*F + (F+1) +: F+1];
        r1_w <= i_entry[HB + 3*F + 2*(F+1) +: F+1];
        for (int k = 0; k < 4; k++) begin
            r2_lx[k] <= lerp(r1_u, LW'(r1_g[2*k]), LW'(r1_g[2*k+1]));
        end
        r2_v <= r1_v;
        r2_w <= r1_w;
        for (int k = 0; k < 2; k++) begin
            r3_ly[k] <= lerp(r2_v, r2_lx[2*k], r2_lx[2*k+1]);
        end
        r3_w <= r2_w;
        r4_res <= lerp(r3_w, r3_ly[0], r3_ly[1]);
        if (n_scaled > VW'(pn3_pkg::NOISE_MAX)) begin
            o_noise_value <= pn3_pkg::NOISE_MAX;
        end else begin
            o_noise_value <= pn3_pkg::NOISE_W'(n_scaled);
        end
    end

    assign o_valid = r_vld[5];
endmodule
`default_nettype wire
